// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the filter block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define IDF1_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define IDF1_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/idf1_pkg.sv =====
// Shared constants and types of the direct form I filter.
`timescale 1ns / 1ps

package idf1_pkg;

    // Default sizes of the filter.
    localparam int SAMPLE_WIDTH_DEF   = 24;
    localparam int COEF_WIDTH_DEF     = 26;
    localparam int COEF_FRAC_BITS_DEF = 22;
    localparam int MAX_ORDER_DEF      = 4;

    // The register map always carries four delay taps.
    localparam int TAP_COUNT       = 4;
    localparam int ORDER_WIDTH     = 3;
    localparam int REG_INDEX_WIDTH = 3;

    typedef logic [REG_INDEX_WIDTH-1:0] reg_index_t;

    // Configuration register indexes.
    localparam reg_index_t REG_FEEDFORWARD_01 = 3'd0;
    localparam reg_index_t REG_FEEDFORWARD_23 = 3'd1;
    localparam reg_index_t REG_FEEDFORWARD_4  = 3'd2;
    localparam reg_index_t REG_FEEDBACK_12    = 3'd3;
    localparam reg_index_t REG_FEEDBACK_34    = 3'd4;
    localparam reg_index_t REG_FILTER_ORDER   = 3'd5;

    // Control handed to each tap cell.
    typedef struct packed {
        logic shift;
        logic tap_on;
    } cell_ctl_t;

endpackage

// ===== sv/idf1_in_if.sv =====
// Sample channel interface: valid, ready and one signed input sample.
`timescale 1ns / 1ps

interface idf1_in_if #(
    parameter int SAMPLE_WIDTH = idf1_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_in;

    modport source (output valid, output sample_in, input ready);
    modport sink (input valid, input sample_in, output ready);
endinterface

// ===== sv/idf1_out_if.sv =====
// Result channel interface: valid, ready, the filtered sample and its clip flag.
`timescale 1ns / 1ps

interface idf1_out_if #(
    parameter int SAMPLE_WIDTH = idf1_pkg::SAMPLE_WIDTH_DEF
);
    logic                           valid;
    logic                           ready;
    logic signed [SAMPLE_WIDTH-1:0] sample_out;
    logic                           clipped;

    modport source (output valid, output sample_out, output clipped, input ready);
    modport sink (input valid, input sample_out, input clipped, output ready);
endinterface

// ===== sv/idf1_cell.sv =====
// One delay tap of the filter: holds x[n-k] and y[n-k] and adds its products.
`timescale 1ns / 1ps

module idf1_cell #(
    parameter int SAMPLE_WIDTH = idf1_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH   = idf1_pkg::COEF_WIDTH_DEF,
    parameter int ACC_WIDTH    = SAMPLE_WIDTH + COEF_WIDTH + 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  idf1_pkg::cell_ctl_t            ctl,
    input  logic signed [SAMPLE_WIDTH-1:0] x_in,
    input  logic signed [SAMPLE_WIDTH-1:0] y_in,
    input  logic signed [COEF_WIDTH-1:0]   b_coef,
    input  logic signed [COEF_WIDTH-1:0]   a_coef,
    input  logic signed [ACC_WIDTH-1:0]    sum_in,
    output logic signed [SAMPLE_WIDTH-1:0] x_tap,
    output logic signed [SAMPLE_WIDTH-1:0] y_tap,
    output logic signed [ACC_WIDTH-1:0]    sum_out
);
    localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;

    logic signed [SAMPLE_WIDTH-1:0] x_reg;
    logic signed [SAMPLE_WIDTH-1:0] y_reg;
    logic signed [PROD_WIDTH-1:0]   ff_prod;
    logic signed [PROD_WIDTH-1:0]   fb_prod;
    logic signed [ACC_WIDTH-1:0]    tap_term;

    // History shifts one place down the row on every accepted transaction.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg <= '0;
            y_reg <= '0;
        end
        else if (ctl.shift)
        begin
            x_reg <= x_in;
            y_reg <= y_in;
        end
    end

    assign x_tap = x_reg;
    assign y_tap = y_reg;

    // Feedforward product minus feedback product, added to the running sum when the tap is on.
    assign ff_prod  = b_coef * x_reg;
    assign fb_prod  = a_coef * y_reg;
    assign tap_term = ACC_WIDTH'(ff_prod) - ACC_WIDTH'(fb_prod);
    assign sum_out  = ctl.tap_on ? (sum_in + tap_term) : sum_in;

endmodule

// ===== sv/idf1_out_stage.sv =====
// Rounding, saturation and the output register of the filter.
`timescale 1ns / 1ps

module idf1_out_stage #(
    parameter int SAMPLE_WIDTH   = idf1_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH     = idf1_pkg::COEF_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = idf1_pkg::COEF_FRAC_BITS_DEF,
    parameter int ACC_WIDTH      = SAMPLE_WIDTH + COEF_WIDTH + 5
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [ACC_WIDTH-1:0]    acc,
    input  logic                           take,
    input  logic                           result_ready,
    output logic signed [SAMPLE_WIDTH-1:0] y_sat,
    output logic                           can_take,
    output logic                           result_valid,
    output logic signed [SAMPLE_WIDTH-1:0] sample_out,
    output logic                           clipped
);
    localparam int SH_WIDTH = ACC_WIDTH - COEF_FRAC_BITS;

    localparam logic signed [ACC_WIDTH-1:0] HALF = ACC_WIDTH'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [SH_WIDTH-1:0]  HI   =
        {{(SH_WIDTH - SAMPLE_WIDTH + 1){1'b0}}, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SH_WIDTH-1:0]  LO   =
        {{(SH_WIDTH - SAMPLE_WIDTH + 1){1'b1}}, {(SAMPLE_WIDTH - 1){1'b0}}};

    logic signed [ACC_WIDTH-1:0]    rounded;
    logic signed [ACC_WIDTH-1:0]    shifted_full;
    logic signed [SH_WIDTH-1:0]     shifted;
    logic                           clip_now;
    logic                           valid_reg;
    logic                           valid_next;
    logic signed [SAMPLE_WIDTH-1:0] sample_reg;
    logic                           clipped_reg;

    // Round half up, floor shift, then clamp to the sample range.
    always_comb
    begin
        rounded      = acc + HALF;
        shifted_full = rounded >>> COEF_FRAC_BITS;
        shifted      = shifted_full[SH_WIDTH-1:0];
        if (shifted > HI)
        begin
            y_sat    = HI[SAMPLE_WIDTH-1:0];
            clip_now = 1'b1;
        end
        else if (shifted < LO)
        begin
            y_sat    = LO[SAMPLE_WIDTH-1:0];
            clip_now = 1'b1;
        end
        else
        begin
            y_sat    = shifted[SAMPLE_WIDTH-1:0];
            clip_now = 1'b0;
        end
    end

    // The register frees up in the same cycle its result is taken.
    assign can_take   = !valid_reg || result_ready;
    assign valid_next = take ? 1'b1 : (result_ready ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Result payload loads with each accepted transaction.
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            sample_reg  <= y_sat;
            clipped_reg <= clip_now;
        end
    end

    assign result_valid = valid_reg;
    assign sample_out   = sample_reg;
    assign clipped      = clipped_reg;

endmodule

// ===== sv/iir_direct_form_one_filter.sv =====
// Top level of the direct form I IIR filter, order 1 to 4.
`timescale 1ns / 1ps

// The filter takes one sample per clock and returns its result on the next
// clock: throughput is one transaction per cycle unless a result is stalled,
// with the output register letting a new sample in while a result is being
// taken. The rate is set by the feedback recurrence: y[n-1] from the previous
// transaction enters the products of the current one, so all nine products,
// their sum, the rounding and the saturation are done in the accept cycle.
// Each tap cell holds one step of input and output history and adds its two
// products to the sum handed on by its neighbor. Histories reset to zero and
// always shift through every cell, whatever the configured order.
module iir_direct_form_one_filter #(
    parameter int SAMPLE_WIDTH   = idf1_pkg::SAMPLE_WIDTH_DEF,
    parameter int COEF_WIDTH     = idf1_pkg::COEF_WIDTH_DEF,
    parameter int COEF_FRAC_BITS = idf1_pkg::COEF_FRAC_BITS_DEF,
    parameter int MAX_ORDER      = idf1_pkg::MAX_ORDER_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    idf1_in_if.sink                     sample_chan,
    idf1_out_if.source                  result_chan,
    input  logic                        cfg_wr_en,
    input  idf1_pkg::reg_index_t        cfg_index,
    input  logic [2*COEF_WIDTH-1:0]     cfg_wdata
);
    localparam int ACC_WIDTH  = SAMPLE_WIDTH + COEF_WIDTH + 5;
    localparam int PROD_WIDTH = SAMPLE_WIDTH + COEF_WIDTH;
    localparam int TAPS       = idf1_pkg::TAP_COUNT;
    localparam int OW         = idf1_pkg::ORDER_WIDTH;

    localparam logic signed [COEF_WIDTH-1:0] B0_RESET = COEF_WIDTH'(1) << COEF_FRAC_BITS;
    localparam logic [OW-1:0]                ORDER_RESET = OW'(1);

    logic signed [COEF_WIDTH-1:0]   b_reg [0:TAPS];
    logic signed [COEF_WIDTH-1:0]   a_reg [1:TAPS];
    logic [OW-1:0]                  order_reg;

    logic                           accept;
    logic                           can_take;
    logic signed [PROD_WIDTH-1:0]   head_prod;
    logic signed [SAMPLE_WIDTH-1:0] y_new;
    logic signed [SAMPLE_WIDTH-1:0] x_chain   [0:MAX_ORDER];
    logic signed [SAMPLE_WIDTH-1:0] y_chain   [0:MAX_ORDER];
    logic signed [ACC_WIDTH-1:0]    sum_chain [0:MAX_ORDER];

    // Configuration registers; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg[0] <= B0_RESET;
            for (int i = 1; i <= TAPS; i++)
            begin
                b_reg[i] <= '0;
                a_reg[i] <= '0;
            end
            order_reg <= ORDER_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                idf1_pkg::REG_FEEDFORWARD_01:
                begin
                    b_reg[0] <= cfg_wdata[COEF_WIDTH-1:0];
                    b_reg[1] <= cfg_wdata[2*COEF_WIDTH-1:COEF_WIDTH];
                end
                idf1_pkg::REG_FEEDFORWARD_23:
                begin
                    b_reg[2] <= cfg_wdata[COEF_WIDTH-1:0];
                    b_reg[3] <= cfg_wdata[2*COEF_WIDTH-1:COEF_WIDTH];
                end
                idf1_pkg::REG_FEEDFORWARD_4:
                begin
                    b_reg[4] <= cfg_wdata[COEF_WIDTH-1:0];
                end
                idf1_pkg::REG_FEEDBACK_12:
                begin
                    a_reg[1] <= cfg_wdata[COEF_WIDTH-1:0];
                    a_reg[2] <= cfg_wdata[2*COEF_WIDTH-1:COEF_WIDTH];
                end
                idf1_pkg::REG_FEEDBACK_34:
                begin
                    a_reg[3] <= cfg_wdata[COEF_WIDTH-1:0];
                    a_reg[4] <= cfg_wdata[2*COEF_WIDTH-1:COEF_WIDTH];
                end
                idf1_pkg::REG_FILTER_ORDER:
                begin
                    order_reg <= cfg_wdata[OW-1:0];
                end
                default:
                begin
                end
            endcase
        end
    end

    // Input handshake.
    assign accept            = sample_chan.valid && can_take;
    assign sample_chan.ready = can_take;

    // Head of the row: the current sample times b0 starts the sum.
    assign head_prod    = b_reg[0] * sample_chan.sample_in;
    assign x_chain[0]   = sample_chan.sample_in;
    assign y_chain[0]   = y_new;
    assign sum_chain[0] = ACC_WIDTH'(head_prod);

    // Row of tap cells; a tap above the order adds nothing (order 0 acts as 1).
    for (genvar k = 1; k <= MAX_ORDER; k++)
    begin : g_tap
        idf1_pkg::cell_ctl_t ctl;

        assign ctl.shift  = accept;
        assign ctl.tap_on = (k == 1) ? 1'b1 : (order_reg >= OW'(k));

        idf1_cell #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .COEF_WIDTH   (COEF_WIDTH),
            .ACC_WIDTH    (ACC_WIDTH)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .ctl     (ctl),
            .x_in    (x_chain[k-1]),
            .y_in    (y_chain[k-1]),
            .b_coef  (b_reg[k]),
            .a_coef  (a_reg[k]),
            .sum_in  (sum_chain[k-1]),
            .x_tap   (x_chain[k]),
            .y_tap   (y_chain[k]),
            .sum_out (sum_chain[k])
        );
    end

    // Rounding, saturation and the result register.
    idf1_out_stage #(
        .SAMPLE_WIDTH   (SAMPLE_WIDTH),
        .COEF_WIDTH     (COEF_WIDTH),
        .COEF_FRAC_BITS (COEF_FRAC_BITS),
        .ACC_WIDTH      (ACC_WIDTH)
    ) u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .acc          (sum_chain[MAX_ORDER]),
        .take         (accept),
        .result_ready (result_chan.ready),
        .y_sat        (y_new),
        .can_take     (can_take),
        .result_valid (result_chan.valid),
        .sample_out   (result_chan.sample_out),
        .clipped      (result_chan.clipped)
    );

endmodule

// ===== sv/idf1_checker.sv =====
// Port-level checks of the filter and their binding to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module idf1_checker #(
    parameter int SAMPLE_WIDTH = idf1_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input logic                           out_valid,
    input logic                           out_ready,
    input logic signed [SAMPLE_WIDTH-1:0] sample_out,
    input logic                           clipped
);
    localparam logic signed [SAMPLE_WIDTH-1:0] HI = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
    localparam logic signed [SAMPLE_WIDTH-1:0] LO = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

    // A stalled result stays put.
    `IDF1_ASSERT_NEXT(a_result_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(clipped), "stalled result changed")

    // Input is refused only while a finished result is stalled.
    `IDF1_ASSERT_NOW(a_ready_rule, clk, rst_n, !in_ready, out_valid && !out_ready, "input refused without a stalled result")

    // Every accepted transaction shows a result on the next cycle.
    `IDF1_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid, "accepted sample gave no result")

    // No result appears without a transaction behind it.
    `IDF1_ASSERT_NEXT(a_no_extra, clk, rst_n, !(in_valid && in_ready) && (!out_valid || out_ready), !out_valid, "result without an accepted sample")

    // A clipped result sits at one end of the sample range.
    `IDF1_ASSERT_NOW(a_clip_value, clk, rst_n, out_valid && clipped, (sample_out == HI) || (sample_out == LO), "clipped result not at a range limit")

endmodule

bind iir_direct_form_one_filter idf1_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_idf1_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample_chan.valid),
    .in_ready   (sample_chan.ready),
    .out_valid  (result_chan.valid),
    .out_ready  (result_chan.ready),
    .sample_out (result_chan.sample_out),
    .clipped    (result_chan.clipped)
);
